// ===== sv/sha256_byte_stream_hasher_defines.svh =====
// Assertion helpers used by shs_ctrl.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Implication checked on every clock, off while in reset.
`define SHS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define SHS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== sv/shs_pkg.sv =====
package shs_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned LenBytePos = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [1:0] {
    BS_DATA,
    BS_PAD,
    BS_ZERO,
    BS_LEN
  } byte_sel_e;

  typedef struct packed {
    logic        shift;
    byte_sel_e   sel;
    logic [2:0]  len_idx;
    logic        latch_len;
    logic [5:0]  fill;
    logic        init_vars;
    logic        round;
    logic [5:0]  rnd;
    logic        add;
    logic        bump;
    logic        restart;
    logic [2:0]  widx;
  } shs_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv(input logic [2:0] i);
    case (i)
      3'd0: iv = 32'h6a09e667;
      3'd1: iv = 32'hbb67ae85;
      3'd2: iv = 32'h3c6ef372;
      3'd3: iv = 32'ha54ff53a;
      3'd4: iv = 32'h510e527f;
      3'd5: iv = 32'h9b05688c;
      3'd6: iv = 32'h1f83d9ab;
      default: iv = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] kconst(input logic [5:0] r);
    case (r)
      6'd0: kconst = 32'h428a2f98;  6'd1: kconst = 32'h71374491;
      6'd2: kconst = 32'hb5c0fbcf;  6'd3: kconst = 32'he9b5dba5;
      6'd4: kconst = 32'h3956c25b;  6'd5: kconst = 32'h59f111f1;
      6'd6: kconst = 32'h923f82a4;  6'd7: kconst = 32'hab1c5ed5;
      6'd8: kconst = 32'hd807aa98;  6'd9: kconst = 32'h12835b01;
      6'd10: kconst = 32'h243185be; 6'd11: kconst = 32'h550c7dc3;
      6'd12: kconst = 32'h72be5d74; 6'd13: kconst = 32'h80deb1fe;
      6'd14: kconst = 32'h9bdc06a7; 6'd15: kconst = 32'hc19bf174;
      6'd16: kconst = 32'he49b69c1; 6'd17: kconst = 32'hefbe4786;
      6'd18: kconst = 32'h0fc19dc6; 6'd19: kconst = 32'h240ca1cc;
      6'd20: kconst = 32'h2de92c6f; 6'd21: kconst = 32'h4a7484aa;
      6'd22: kconst = 32'h5cb0a9dc; 6'd23: kconst = 32'h76f988da;
      6'd24: kconst = 32'h983e5152; 6'd25: kconst = 32'ha831c66d;
      6'd26: kconst = 32'hb00327c8; 6'd27: kconst = 32'hbf597fc7;
      6'd28: kconst = 32'hc6e00bf3; 6'd29: kconst = 32'hd5a79147;
      6'd30: kconst = 32'h06ca6351; 6'd31: kconst = 32'h14292967;
      6'd32: kconst = 32'h27b70a85; 6'd33: kconst = 32'h2e1b2138;
      6'd34: kconst = 32'h4d2c6dfc; 6'd35: kconst = 32'h53380d13;
      6'd36: kconst = 32'h650a7354; 6'd37: kconst = 32'h766a0abb;
      6'd38: kconst = 32'h81c2c92e; 6'd39: kconst = 32'h92722c85;
      6'd40: kconst = 32'ha2bfe8a1; 6'd41: kconst = 32'ha81a664b;
      6'd42: kconst = 32'hc24b8b70; 6'd43: kconst = 32'hc76c51a3;
      6'd44: kconst = 32'hd192e819; 6'd45: kconst = 32'hd6990624;
      6'd46: kconst = 32'hf40e3585; 6'd47: kconst = 32'h106aa070;
      6'd48: kconst = 32'h19a4c116; 6'd49: kconst = 32'h1e376c08;
      6'd50: kconst = 32'h2748774c; 6'd51: kconst = 32'h34b0bcb5;
      6'd52: kconst = 32'h391c0cb3; 6'd53: kconst = 32'h4ed8aa4a;
      6'd54: kconst = 32'h5b9cca4f; 6'd55: kconst = 32'h682e6ff3;
      6'd56: kconst = 32'h748f82ee; 6'd57: kconst = 32'h78a5636f;
      6'd58: kconst = 32'h84c87814; 6'd59: kconst = 32'h8cc70208;
      6'd60: kconst = 32'h90befffa; 6'd61: kconst = 32'ha4506ceb;
      6'd62: kconst = 32'hbef9a3f7; default: kconst = 32'hc67178f2;
    endcase
  endfunction

endpackage

// ===== sv/shs_ctrl.sv =====
module shs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tuser_i,
  output logic              s_axis_tready_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic              m_axis_tlast_o,
  output shs_pkg::shs_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_RND,
    S_ADD,
    S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] oidx_q, oidx_d;
  logic       fin_q, fin_d;
  logic       xblk_q, xblk_d;
  logic       in_xfer;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tlast_o  = (oidx_q == 3'd7);
  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    fin_d   = fin_q;
    xblk_d  = xblk_q;
    cmd_o   = '0;
    cmd_o.sel     = shs_pkg::BS_DATA;
    cmd_o.fill    = fill_q;
    cmd_o.rnd     = rnd_q;
    cmd_o.widx    = oidx_q;
    cmd_o.len_idx = ~fill_q[2:0];
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.shift = 1'b1;
          fill_d = fill_q + 6'd1;
          if (s_axis_tuser_i) begin
            cmd_o.sel = shs_pkg::BS_PAD;
            cmd_o.latch_len = 1'b1;
            fin_d  = 1'b1;
            xblk_d = (fill_q >= 6'(shs_pkg::LenBytePos));
            state_d = S_PAD;
          end else begin
            fin_d = 1'b0;
          end
          if (fill_q == 6'd63) begin
            cmd_o.init_vars = 1'b1;
            state_d = S_RND;
          end
        end
      end
      S_PAD: begin
        cmd_o.shift = 1'b1;
        fill_d = fill_q + 6'd1;
        if (!xblk_q && fill_q >= 6'(shs_pkg::LenBytePos)) begin
          cmd_o.sel = shs_pkg::BS_LEN;
        end else begin
          cmd_o.sel = shs_pkg::BS_ZERO;
        end
        if (fill_q == 6'd63) begin
          cmd_o.init_vars = 1'b1;
          state_d = S_RND;
        end
      end
      S_RND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add  = 1'b1;
        cmd_o.bump = ~fin_q;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (xblk_q) begin
          xblk_d  = 1'b0;
          state_d = S_PAD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            fin_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      xblk_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      fin_q   <= fin_d;
      xblk_q  <= xblk_d;
    end
  end

`include "sha256_byte_stream_hasher_defines.svh"

  `SHS_NEVER(a_rnd_idle, state_q != S_RND && rnd_q != 6'd0, "round count off outside rounds")
  `SHS_ASSERT(a_out_empty, state_q == S_OUT, fill_q == 6'd0 && !xblk_q, "block not flushed")
  `SHS_ASSERT(a_blk_full, state_q == S_PAD && fill_q == 6'd63, ##1 state_q == S_RND, "no compress")
  `SHS_ASSERT(a_last_done, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o,
              ##1 state_q == S_IDLE, "digest not closed")

endmodule

// ===== sv/shs_dp.sv =====
module shs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shs_pkg::shs_cmd_t cmd_i,
  input  logic [7:0]        byte_i,
  output logic [31:0]       word_o
);

  logic [511:0]      msg_q, msg_d;
  logic [7:0][31:0]  hash_q, hash_d;
  logic [7:0][31:0]  v_q, v_d;
  logic [63:0]       bits_q, bits_d;
  logic [63:0]       len_q;
  logic [7:0]        new_byte;
  logic [31:0]       w0, w1, w9, w14, wnew, s0, s1, t1, t2;
  logic [31:0]       a, e;

  assign word_o = hash_q[cmd_i.widx];

  always_comb begin
    case (cmd_i.sel)
      shs_pkg::BS_DATA: new_byte = byte_i;
      shs_pkg::BS_PAD:  new_byte = shs_pkg::PadByte;
      shs_pkg::BS_ZERO: new_byte = 8'h00;
      shs_pkg::BS_LEN:  new_byte = len_q[{cmd_i.len_idx, 3'b000} +: 8];
      default:          new_byte = 8'h00;
    endcase
  end

  assign w0  = msg_q[511:480];
  assign w1  = msg_q[479:448];
  assign w9  = msg_q[223:192];
  assign w14 = msg_q[63:32];
  assign s0  = shs_pkg::rotr(w1, 7) ^ shs_pkg::rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = shs_pkg::rotr(w14, 17) ^ shs_pkg::rotr(w14, 19) ^ (w14 >> 10);
  assign wnew = s1 + w9 + s0 + w0;

  assign a  = v_q[0];
  assign e  = v_q[4];
  assign t1 = v_q[7] + (shs_pkg::rotr(e, 6) ^ shs_pkg::rotr(e, 11) ^ shs_pkg::rotr(e, 25))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + shs_pkg::kconst(cmd_i.rnd) + w0;
  assign t2 = (shs_pkg::rotr(a, 2) ^ shs_pkg::rotr(a, 13) ^ shs_pkg::rotr(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    msg_d  = msg_q;
    v_d    = v_q;
    hash_d = hash_q;
    bits_d = bits_q;
    if (cmd_i.shift) begin
      msg_d = {msg_q[503:0], new_byte};
    end else if (cmd_i.round) begin
      msg_d = {msg_q[479:0], wnew};
    end
    if (cmd_i.init_vars) begin
      v_d = hash_q;
    end else if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
    if (cmd_i.add) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + v_q[i];
      end
    end
    if (cmd_i.bump) begin
      bits_d = bits_q + 64'(shs_pkg::BlockBits);
    end
    if (cmd_i.restart) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = shs_pkg::iv(3'(i));
      end
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= shs_pkg::iv(3'(i));
      end
      bits_q <= '0;
    end else begin
      hash_q <= hash_d;
      bits_q <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
    v_q   <= v_d;
    if (cmd_i.latch_len) begin
      len_q <= bits_q + {55'd0, cmd_i.fill, 3'b000};
    end
  end

endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
// A finish transfer gives the first digest word once the padding bytes have gone in
// one a cycle and each compressed block has run its 64 rounds plus one add.
// Throughput: one byte a cycle between blocks; each full block holds the input
// while the single round unit runs. Digest words go out one a cycle while m_axis_tready_i is high.
// Reset: async active low; loads the initial hash, clears counters, output idle.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] message_byte
  input  logic        s_axis_tuser_i,   // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast_o    // last_word
);

  shs_pkg::shs_cmd_t cmd;
  logic [31:0]       word;

  shs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_o           (cmd)
  );

  shs_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .byte_i (s_axis_tdata_i),
    .word_o (word)
  );

  assign m_axis_tdata_o = {5'd0, cmd.widx, word};

endmodule
